// File: design/epaf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epaf_pkg
// shared types, constants and rounding helpers for the steering pid block
// ----------------------------------------------------------------------------
package epaf_pkg;

  // field widths
  localparam int ERR_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int LIM_W   = 15;
  localparam int DRV_W   = 16;
  localparam int CIDX_W  = 3;
  localparam int MA_W    = 36;
  localparam int MB_W    = 17;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int ACC_W   = 48;
  localparam int RND_W   = ACC_W - 8;

  // thresholds, error in q11.4, output in q.12
  localparam logic signed [ERR_W-1:0] ERR_DEAD  = 16'sd48;
  localparam logic signed [ERR_W-1:0] DIR_BAND  = 16'sd128;
  localparam logic [ERR_W:0]          SMALL_ERR = 17'd320;
  localparam logic [ERR_W:0]          MID_ERR   = 17'd560;
  localparam logic [ERR_W:0]          LARGE_ERR = 17'd1200;
  localparam logic signed [RND_W-1:0] OUT_DEAD  = 40'sd12288;

  // signed q8.8 filter and scale factors
  localparam logic signed [MB_W-1:0] K_D_NEW = 17'sd179;
  localparam logic signed [MB_W-1:0] K_D_OLD = 17'sd77;
  localparam logic signed [MB_W-1:0] K_O_NEW = 17'sd218;
  localparam logic signed [MB_W-1:0] K_O_OLD = 17'sd38;
  localparam logic signed [MB_W-1:0] K_SMALL = 17'sd166;
  localparam logic signed [MB_W-1:0] K_GROW  = 17'sd275;
  localparam logic signed [MB_W-1:0] K_UNIT  = 17'sd256;

  // register reset values
  localparam logic [LIM_W-1:0] INTEG_LIMIT_RST = 15'd6400;
  localparam logic [LIM_W-1:0] DRIVE_LIMIT_RST = 15'd1000;

  // configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_INTEG_LIMIT = 3'd3,
    REG_DRIVE_LIMIT = 3'd4
  } cfg_reg_t;

  // direction codes
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_NEG  = 2'd1,
    DIR_POS  = 2'd2
  } dir_t;

  // datapath step commands
  typedef enum logic [3:0] {
    STEP_IDLE,
    STEP_LOAD,
    STEP_PREP,
    STEP_DPROD,
    STEP_DN1,
    STEP_DN2,
    STEP_DN3,
    STEP_S1,
    STEP_S2,
    STEP_K,
    STEP_LIM,
    STEP_O1,
    STEP_O2,
    STEP_O3,
    STEP_COMMIT
  } step_t;

  typedef struct packed {
    step_t step;
  } epaf_cmd_t;

  // floor((v + 128) / 256)
  function automatic logic signed [RND_W-1:0] round_q8(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v + 48'sd128;
    return t[ACC_W-1:8];
  endfunction

  // saturate to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [RND_W-1:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/epaf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epaf_ctrl
// sequencer: steps the datapath through one sample and owns the handshakes
// ----------------------------------------------------------------------------
module epaf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output epaf_pkg::epaf_cmd_t    cmd
);
  import epaf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DPROD,
    ST_DN1,
    ST_DN2,
    ST_DN3,
    ST_S1,
    ST_S2,
    ST_K,
    ST_LIM,
    ST_O1,
    ST_O2,
    ST_O3,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  // next state, command and output valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.step      = STEP_IDLE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.step  = STEP_LOAD;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP:  begin cmd.step = STEP_PREP;  state_nxt = ST_DPROD; end
      ST_DPROD: begin cmd.step = STEP_DPROD; state_nxt = ST_DN1;   end
      ST_DN1:   begin cmd.step = STEP_DN1;   state_nxt = ST_DN2;   end
      ST_DN2:   begin cmd.step = STEP_DN2;   state_nxt = ST_DN3;   end
      ST_DN3:   begin cmd.step = STEP_DN3;   state_nxt = ST_S1;    end
      ST_S1:    begin cmd.step = STEP_S1;    state_nxt = ST_S2;    end
      ST_S2:    begin cmd.step = STEP_S2;    state_nxt = ST_K;     end
      ST_K:     begin cmd.step = STEP_K;     state_nxt = ST_LIM;   end
      ST_LIM:   begin cmd.step = STEP_LIM;   state_nxt = ST_O1;    end
      ST_O1:    begin cmd.step = STEP_O1;    state_nxt = ST_O2;    end
      ST_O2:    begin cmd.step = STEP_O2;    state_nxt = ST_O3;    end
      ST_O3:    begin cmd.step = STEP_O3;    state_nxt = ST_DONE;  end
      ST_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.step      = STEP_COMMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/epaf_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epaf_dp
// datapath: config registers, controller state, one shared multiplier
// ----------------------------------------------------------------------------
module epaf_dp (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire epaf_pkg::epaf_cmd_t                   cmd,
  input  wire logic signed [epaf_pkg::ERR_W-1:0]     in_steer_error,
  input  wire logic                                  cfg_we,
  input  wire logic [epaf_pkg::CIDX_W-1:0]           cfg_index,
  input  wire logic [epaf_pkg::GAIN_W-1:0]           cfg_data,
  output logic signed [epaf_pkg::DRV_W-1:0]          out_drive_value,
  output logic [1:0]                                 out_direction
);
  import epaf_pkg::*;

  // configuration
  logic [GAIN_W-1:0] prop_gain_r, integ_gain_r, deriv_gain_r;
  logic [LIM_W-1:0]  integ_limit_r, drive_limit_r;

  // controller state
  logic signed [ERR_W-1:0] prev_error_r, older_error_r, error_sum_r;
  logic signed [31:0]      deriv_filt_r, prev_output_r;

  // per-sample working registers
  logic signed [ERR_W-1:0]  e_r, sum_r;
  dir_t                     dir_r;
  logic signed [MB_W-1:0]   k_r;
  logic signed [31:0]       dnew_r, y_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [DRV_W-1:0]  drive_r;
  dir_t                     odir_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r   <= '0;
      integ_gain_r  <= '0;
      deriv_gain_r  <= '0;
      integ_limit_r <= INTEG_LIMIT_RST;
      drive_limit_r <= DRIVE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROP_GAIN:   prop_gain_r   <= cfg_data;
        REG_INTEG_GAIN:  integ_gain_r  <= cfg_data;
        REG_DERIV_GAIN:  deriv_gain_r  <= cfg_data;
        REG_INTEG_LIMIT: integ_limit_r <= cfg_data[LIM_W-1:0];
        REG_DRIVE_LIMIT: drive_limit_r <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // input deadband
  logic signed [ERR_W-1:0] e_in;
  assign e_in = (in_steer_error > -ERR_DEAD && in_steer_error < ERR_DEAD) ? '0
                                                                           : in_steer_error;

  // clamped error sum
  logic signed [ERR_W:0] sum_raw, il;
  logic signed [ERR_W-1:0] sum_c;
  always_comb begin
    sum_raw = {error_sum_r[ERR_W-1], error_sum_r} + {e_r[ERR_W-1], e_r};
    il      = $signed({2'b00, integ_limit_r});
    if (sum_raw > il) begin
      sum_c = il[ERR_W-1:0];
    end else if (sum_raw < -il) begin
      sum_c = 16'(-il);
    end else begin
      sum_c = sum_raw[ERR_W-1:0];
    end
  end

  // direction from the deadbanded error
  dir_t dir_c;
  always_comb begin
    priority if (e_r < -DIR_BAND) dir_c = DIR_NEG;
    else if (e_r > DIR_BAND)      dir_c = DIR_POS;
    else                          dir_c = DIR_NONE;
  end

  // integer part of an error, truncated toward zero
  function automatic logic signed [11:0] int_part(input logic signed [ERR_W-1:0] x);
    logic signed [ERR_W:0] t;
    t = {x[ERR_W-1], x} + (x[ERR_W-1] ? 17'sd15 : 17'sd0);
    return t[ERR_W-1:4];
  endfunction

  // gain regime and growth test
  logic [ERR_W:0]          ae;
  logic signed [11:0]      tn, tl, tll;
  logic signed [12:0]      d1, d2;
  logic                    pos1, pos2, grow;
  logic signed [MB_W-1:0]  k_c;
  always_comb begin
    ae   = e_r[ERR_W-1] ? (17'd0 - {e_r[ERR_W-1], e_r}) : {1'b0, e_r};
    tn   = int_part(e_r);
    tl   = int_part(prev_error_r);
    tll  = int_part(older_error_r);
    d1   = {tn[11], tn} - {tl[11], tl};
    d2   = {tl[11], tl} - {tll[11], tll};
    pos1 = (tn != '0) && (d1 != '0) && (tn[11] == d1[12]);
    pos2 = (tl != '0) && (d2 != '0) && (tl[11] == d2[12]);
    grow = (pos1 && pos2) || (tn == tl);
    priority if (ae < SMALL_ERR)        k_c = K_SMALL;
    else if (ae > LARGE_ERR)            k_c = K_UNIT;
    else if (grow && (ae > MID_ERR))    k_c = K_GROW;
    else                                k_c = K_UNIT;
  end

  // shared multiplier operand selection
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [ERR_W:0]    ediff;
  assign ediff = {e_r[ERR_W-1], e_r} - {prev_error_r[ERR_W-1], prev_error_r};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.step)
      STEP_DPROD: begin mul_a = MA_W'(ediff);         mul_b = $signed({1'b0, deriv_gain_r}); end
      STEP_DN1:   begin mul_a = prod_r[MA_W-1:0];     mul_b = K_D_NEW; end
      STEP_DN2:   begin mul_a = MA_W'(deriv_filt_r);  mul_b = K_D_OLD; end
      STEP_DN3:   begin mul_a = MA_W'(e_r);           mul_b = $signed({1'b0, prop_gain_r}); end
      STEP_S1:    begin mul_a = MA_W'(sum_r);         mul_b = $signed({1'b0, integ_gain_r}); end
      STEP_K:     begin mul_a = acc_r[MA_W-1:0];      mul_b = k_r; end
      STEP_O1:    begin mul_a = acc_r[MA_W-1:0];      mul_b = K_O_NEW; end
      STEP_O2:    begin mul_a = MA_W'(prev_output_r); mul_b = K_O_OLD; end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // rounding, limiting and output shaping
  logic signed [ACC_W-1:0] prod_lo, acc_sum;
  logic signed [RND_W-1:0] rnd_sum, rnd_prod, lim_s, lim_c, y_c;
  always_comb begin
    prod_lo  = prod_r[ACC_W-1:0];
    acc_sum  = acc_r + prod_lo;
    rnd_sum  = round_q8(acc_sum);
    rnd_prod = round_q8(prod_lo);
    lim_s    = $signed({13'd0, drive_limit_r, 12'd0});
    if (rnd_prod > lim_s) begin
      lim_c = lim_s;
    end else if (rnd_prod < -lim_s) begin
      lim_c = -lim_s;
    end else begin
      lim_c = rnd_prod;
    end
    y_c = (rnd_sum > -OUT_DEAD && rnd_sum < OUT_DEAD) ? '0 : rnd_sum;
  end

  // drive truncated toward zero and saturated
  logic signed [32:0]       y_adj;
  logic signed [20:0]       y_int;
  logic signed [DRV_W-1:0]  drive_c;
  always_comb begin
    y_adj = {y_r[31], y_r} + (y_r[31] ? 33'sd4095 : 33'sd0);
    y_int = y_adj[32:12];
    if (y_int > 21'sd32767) begin
      drive_c = 16'sd32767;
    end else if (y_int < -21'sd32767) begin
      drive_c = -16'sd32767;
    end else begin
      drive_c = y_int[DRV_W-1:0];
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd.step)
      STEP_LOAD: e_r <= e_in;
      STEP_PREP: begin
        sum_r <= sum_c;
        dir_r <= dir_c;
        k_r   <= k_c;
      end
      STEP_DPROD, STEP_DN1, STEP_K, STEP_O1: prod_r <= mul_p;
      STEP_DN2, STEP_O2: begin
        acc_r  <= prod_lo;
        prod_r <= mul_p;
      end
      STEP_DN3: begin
        dnew_r <= sat32(rnd_sum);
        prod_r <= mul_p;
      end
      STEP_S1: begin
        acc_r  <= prod_lo + ACC_W'(dnew_r);
        prod_r <= mul_p;
      end
      STEP_S2:  acc_r <= acc_sum;
      STEP_LIM: acc_r <= ACC_W'(lim_c);
      STEP_O3:  y_r   <= sat32(y_c);
      STEP_COMMIT: begin
        drive_r <= drive_c;
        odir_r  <= dir_r;
      end
      default: ;
    endcase
  end

  // controller state update at the end of a sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_error_r  <= '0;
      older_error_r <= '0;
      error_sum_r   <= '0;
      deriv_filt_r  <= '0;
      prev_output_r <= '0;
    end else if (cmd.step == STEP_COMMIT) begin
      older_error_r <= prev_error_r;
      prev_error_r  <= e_r;
      error_sum_r   <= sum_r;
      deriv_filt_r  <= dnew_r;
      prev_output_r <= y_r;
    end
  end

  assign out_drive_value = drive_r;
  assign out_direction   = odir_r;

endmodule
`default_nettype wire

// File: design/expert_pid_angle_filtered.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// expert_pid_angle_filtered
// fixed-point steering pid with error-regime gain and filtered output
// ----------------------------------------------------------------------------
// One steering-error sample (q11.4) goes in, one drive value and direction
// flag come out. A sample is taken only while the block is idle; its result
// is presented once the sequencer has stepped through its states, and a new
// sample can be accepted after the commit, which waits while the output side
// stalls. The pace is set by a single shared 36x17 multiplier that
// the sequencer steps through eight products per sample. The finished result
// sits in an output register, so the next sample may start while it waits;
// a second result is held back until the first has been taken. cfg_ready is
// always high; registers should only be written while the block is idle and
// take effect from the next sample.
module expert_pid_angle_filtered (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // input transaction
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [epaf_pkg::ERR_W-1:0]     in_steer_error,
  // result transaction
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [epaf_pkg::DRV_W-1:0]          out_drive_value,
  output logic [1:0]                                 out_direction,
  // configuration writes
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [epaf_pkg::CIDX_W-1:0]           cfg_index,
  input  wire logic [epaf_pkg::GAIN_W-1:0]           cfg_data
);
  import epaf_pkg::*;

  epaf_cmd_t cmd;

  assign cfg_ready = 1'b1;

  // sequencer
  epaf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // arithmetic and state
  epaf_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_steer_error  (in_steer_error),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_drive_value (out_drive_value),
    .out_direction   (out_direction)
  );

  // a new result only ever follows a commit step
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.step == STEP_COMMIT))
    else $error("result raised without a commit");

  // an accepted sample always starts the sequence
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (in_stall && cmd.step == STEP_PREP))
    else $error("sequence did not start after accept");

  // a commit never overwrites a result still waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step == STEP_COMMIT) |-> (!out_valid || !out_stall))
    else $error("pending result overwritten");

  // drive is saturated symmetrically
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_drive_value != -16'sd32768))
    else $error("drive outside symmetric range");

endmodule
`default_nettype wire
